>>> rtl/krht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krht_pkg
// Shared types, widths and codes of the keyed record hash table.
// ----------------------------------------------------------------------------
package krht_pkg;

    localparam int BUCKETS_DEF = 64;
    localparam int WAYS_DEF    = 4;

    localparam int OP_W      = 2;
    localparam int KEY_W     = 31;
    localparam int SEM_W     = 4;
    localparam int GRADE_W   = 10;
    localparam int SKILL_W   = 10;
    localparam int PAY_W     = SEM_W + GRADE_W + SKILL_W;
    localparam int STATUS_W  = 2;
    localparam int CNT_W     = 9;
    localparam int COLL_W    = 16;

    // The key is reduced modulo the bucket count eight bits (MOD_BITS) per cycle.
    localparam int KEYP_W    = 32;
    localparam int MOD_BITS  = 8;
    localparam int MOD_STEPS = KEYP_W / MOD_BITS;
    localparam int MSTEP_W   = $clog2(MOD_STEPS);

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_UPDATE = 2'd2,
        OP_REMOVE = 2'd3
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_DUPLICATE = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef struct packed {
        logic [SKILL_W-1:0] skill;
        logic [GRADE_W-1:0] grade;
        logic [SEM_W-1:0]   semester;
    } t_payload;

    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        t_payload           payload;
    } t_entry;

endpackage

>>> rtl/keyed_record_hash_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_record_hash_table
// Record table keyed by a 31-bit value, with a fixed number of ways per bucket.
// ----------------------------------------------------------------------------
// After reset the block clears the entry store, one entry per cycle for all
// BUCKETS*WAYS entries, and accepts no word until that pass ends. Each
// operation then runs from acceptance through these steps: the shared
// compare-subtract unit reduces the key modulo BUCKETS, eight bits a cycle,
// over MOD_STEPS steps; the entry memory is then read once per way and the
// key comparator checks each returned entry in the cycle after its read;
// the result is then written back and posted, once the output register is
// free or being taken, and the block returns to idle. A finished
// result waits in the output register while the next word is accepted.
module keyed_record_hash_table
    import krht_pkg::*;
#(
    parameter int BUCKETS = BUCKETS_DEF,
    parameter int WAYS    = WAYS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [OP_W-1:0]     i_opcode,
    input  logic [KEY_W-1:0]    i_record_key,
    input  logic [SEM_W-1:0]    i_semester,
    input  logic [GRADE_W-1:0]  i_grade_hundredths,
    input  logic [SKILL_W-1:0]  i_skill_score,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [SEM_W-1:0]    o_found_semester,
    output logic [GRADE_W-1:0]  o_found_grade,
    output logic [SKILL_W-1:0]  o_found_skill,
    output logic [CNT_W-1:0]    o_entry_count,
    output logic [COLL_W-1:0]   o_collision_count
);

    localparam int SLOTS   = BUCKETS * WAYS;
    localparam int ADDR_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int BKT_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int REM_W   = BKT_W + 1;
    localparam int WAYI_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int WAYC_W  = $clog2(WAYS + 1);
    localparam int OCC_W   = $clog2(SLOTS + 1);
    localparam int OCCX_W  = OCC_W + CNT_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_SCAN,
        S_EXEC
    } t_state;

    t_state                  r_state;
    logic [ADDR_W-1:0]       r_clr;
    logic [MSTEP_W-1:0]      r_mstep;
    logic [KEYP_W-1:0]       r_kshift;
    logic [BKT_W-1:0]        r_bucket;
    logic [WAYC_W-1:0]       r_way;
    logic                    r_pend;
    logic [WAYI_W-1:0]       r_eval_way;
    logic                    r_hit;
    logic [WAYI_W-1:0]       r_hit_way;
    t_payload                r_hit_pay;
    logic                    r_free;
    logic [WAYI_W-1:0]       r_free_way;
    logic                    r_nonempty;
    t_opcode                 r_op;
    logic [KEY_W-1:0]        r_key;
    t_payload                r_pay;
    logic [OCC_W-1:0]        r_occ;
    logic [COLL_W-1:0]       r_coll;
    logic                    r_ovalid;
    t_status                 r_ostatus;
    t_payload                r_ofound;
    logic [CNT_W-1:0]        r_ocount;
    logic [COLL_W-1:0]       r_ocoll;

    t_entry                  r_mem [SLOTS];
    t_entry                  r_rdata;

    logic [REM_W-1:0]        n_rem;
    logic [WAYI_W-1:0]       n_slot_way;
    logic [ADDR_W-1:0]       n_addr;
    logic                    n_we;
    logic [ADDR_W-1:0]       n_waddr;
    t_entry                  n_wdata;
    t_status                 n_status;
    t_payload                n_found;
    logic [OCC_W-1:0]        n_occ;
    logic [COLL_W-1:0]       n_coll;
    logic [OCCX_W-1:0]       n_occ_ext;
    logic [CNT_W-1:0]        n_count;
    logic                    n_match;
    logic                    n_load;
    logic                    n_scan_done;

    // Shared compare-subtract unit: one modulo digit step per key bit.
    always_comb begin
        n_rem = {1'b0, r_bucket};
        for (int i = 0; i < MOD_BITS; i++) begin
            n_rem = {n_rem[REM_W-2:0], r_kshift[KEYP_W-1-i]};
            if (n_rem >= REM_W'(BUCKETS)) begin
                n_rem = n_rem - REM_W'(BUCKETS);
            end
        end
    end

    always_comb begin
        n_slot_way = r_way[WAYI_W-1:0];
        if (r_state == S_EXEC) begin
            n_slot_way = (r_op == OP_INSERT) ? r_free_way : r_hit_way;
        end
        n_addr = ADDR_W'(ADDR_W'(r_bucket) * ADDR_W'(WAYS) + ADDR_W'(n_slot_way));
    end

    assign n_match     = r_rdata.valid && (r_rdata.key == r_key);
    assign n_scan_done = r_pend && (r_eval_way == WAYI_W'(WAYS - 1));
    assign n_load      = (r_state == S_EXEC) && (!r_ovalid || i_ready);

    always_comb begin
        n_status = ST_OK;
        n_found  = '0;
        n_occ    = r_occ;
        n_coll   = r_coll;
        n_we     = 1'b0;
        n_waddr  = n_addr;
        n_wdata  = '{valid: 1'b1, key: r_key, payload: r_pay};
        case (r_op)
            OP_INSERT: begin
                if (r_hit) begin
                    n_status = ST_DUPLICATE;
                end else if (!r_free) begin
                    n_status = ST_FULL;
                end else begin
                    n_we  = 1'b1;
                    n_occ = r_occ + OCC_W'(1);
                    if (r_nonempty && (r_coll != {COLL_W{1'b1}})) begin
                        n_coll = r_coll + COLL_W'(1);
                    end
                end
            end
            OP_LOOKUP: begin
                if (r_hit) begin
                    n_found = r_hit_pay;
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            OP_UPDATE: begin
                if (r_hit) begin
                    n_we = 1'b1;
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            OP_REMOVE: begin
                if (r_hit) begin
                    n_we          = 1'b1;
                    n_wdata.valid = 1'b0;
                    if (r_occ != '0) begin
                        n_occ = r_occ - OCC_W'(1);
                    end
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            default: begin
                n_status = ST_NOT_FOUND;
            end
        endcase
        if (r_state == S_CLEAR) begin
            n_we    = 1'b1;
            n_waddr = r_clr;
            n_wdata = '0;
        end else if (!n_load) begin
            n_we = 1'b0;
        end
        n_occ_ext = OCCX_W'(n_occ);
        n_count   = (n_occ_ext > OCCX_W'({CNT_W{1'b1}})) ? {CNT_W{1'b1}}
                                                           : n_occ_ext[CNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (n_we) begin
            r_mem[n_waddr] <= n_wdata;
        end
        r_rdata <= r_mem[n_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_mstep  <= '0;
            r_way    <= '0;
            r_pend   <= 1'b0;
            r_occ    <= '0;
            r_coll   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_valid && i_ready && !n_load) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + ADDR_W'(1);
                    if (r_clr == ADDR_W'(SLOTS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_op       <= t_opcode'(i_opcode);
                        r_key      <= i_record_key;
                        r_pay      <= '{skill: i_skill_score, grade: i_grade_hundredths,
                                        semester: i_semester};
                        r_kshift   <= {1'b0, i_record_key};
                        r_bucket   <= '0;
                        r_mstep    <= '0;
                        r_hit      <= 1'b0;
                        r_free     <= 1'b0;
                        r_nonempty <= 1'b0;
                        r_state    <= S_MOD;
                    end
                end
                S_MOD: begin
                    r_bucket <= n_rem[BKT_W-1:0];
                    r_kshift <= r_kshift << MOD_BITS;
                    r_mstep  <= r_mstep + MSTEP_W'(1);
                    if (r_mstep == MSTEP_W'(MOD_STEPS - 1)) begin
                        r_way   <= '0;
                        r_pend  <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_pend <= (r_way != WAYC_W'(WAYS));
                    if (r_way != WAYC_W'(WAYS)) begin
                        r_way      <= r_way + WAYC_W'(1);
                        r_eval_way <= r_way[WAYI_W-1:0];
                    end
                    if (r_pend) begin
                        if (n_match && !r_hit) begin
                            r_hit     <= 1'b1;
                            r_hit_way <= r_eval_way;
                            r_hit_pay <= r_rdata.payload;
                        end
                        if (r_rdata.valid) begin
                            r_nonempty <= 1'b1;
                        end else if (!r_free) begin
                            r_free     <= 1'b1;
                            r_free_way <= r_eval_way;
                        end
                    end
                    if (n_scan_done) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (n_load) begin
                        r_occ     <= n_occ;
                        r_coll    <= n_coll;
                        r_ovalid  <= 1'b1;
                        r_ostatus <= n_status;
                        r_ofound  <= n_found;
                        r_ocount  <= n_count;
                        r_ocoll   <= n_coll;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready           = (r_state == S_IDLE);
    assign o_valid           = r_ovalid;
    assign o_status          = r_ostatus;
    assign o_found_semester  = r_ofound.semester;
    assign o_found_grade     = r_ofound.grade;
    assign o_found_skill     = r_ofound.skill;
    assign o_entry_count     = r_ocount;
    assign o_collision_count = r_ocoll;

`ifndef ASSERT_OFF
    // Only a successful lookup carries a stored record.
    a_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_OK) |->
            (o_found_semester == '0) && (o_found_grade == '0) && (o_found_skill == '0))
        else $error("found fields nonzero on a failed operation");

    // Occupancy moves only when a result is posted.
    a_occ_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_occ != $past(r_occ)) |->
            $past(r_state == S_EXEC) && $past(n_load))
        else $error("occupancy changed outside write-back");

    // The collision count advances only on a successful insert.
    a_coll_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_coll != $past(r_coll)) |->
            $past(r_op == OP_INSERT) && $past(n_status == ST_OK) && $past(n_load))
        else $error("collision count changed without an insert");

    // Occupancy never exceeds the store size.
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_W'(SLOTS))
        else $error("occupancy above store size");
`endif

endmodule

>>> tb/keyed_record_hash_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_record_hash_table_checker
// Watches both channels of the record table, keeps a shadow copy of the
// bucket store and compares every result word with the predicted one.
// ----------------------------------------------------------------------------
module keyed_record_hash_table_checker
    import krht_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic [OP_W-1:0]     i_opcode,
    input  logic [KEY_W-1:0]    i_record_key,
    input  logic [SEM_W-1:0]    i_semester,
    input  logic [GRADE_W-1:0]  i_grade_hundredths,
    input  logic [SKILL_W-1:0]  i_skill_score,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic [STATUS_W-1:0] i_status,
    input  logic [SEM_W-1:0]    i_found_semester,
    input  logic [GRADE_W-1:0]  i_found_grade,
    input  logic [SKILL_W-1:0]  i_found_skill,
    input  logic [CNT_W-1:0]    i_entry_count,
    input  logic [COLL_W-1:0]   i_collision_count,
    output int                  o_fail_count,
    output int                  o_pending
);

    localparam int BUCKETS = BUCKETS_DEF;
    localparam int WAYS    = WAYS_DEF;
    localparam int SLOTS   = BUCKETS * WAYS;

    typedef struct packed {
        t_status            status;
        t_payload           found;
        logic [CNT_W-1:0]   count;
        logic [COLL_W-1:0]  coll;
    } t_reply;

    bit               slot_valid [SLOTS];
    logic [KEY_W-1:0] slot_key   [SLOTS];
    t_payload         slot_pay   [SLOTS];
    int               occupancy;
    int               collisions;
    t_reply           queued_replies[$];
    t_reply           oldest;
    int               mismatches = 0;

    assign o_fail_count = mismatches;

    function automatic t_reply apply_table_op(t_opcode op, logic [KEY_W-1:0] key,
                                              t_payload pay);
        t_reply r;
        int     base;
        int     hit;
        int     free_slot;
        bit     occupied;
        r.status  = ST_OK;
        r.found   = '0;
        base      = int'(key % BUCKETS) * WAYS;
        hit       = -1;
        free_slot = -1;
        occupied  = 1'b0;
        for (int w = 0; w < WAYS; w++) begin
            if (slot_valid[base + w]) begin
                occupied = 1'b1;
                if (hit < 0 && slot_key[base + w] == key) begin
                    hit = base + w;
                end
            end else if (free_slot < 0) begin
                free_slot = base + w;
            end
        end
        if (op == OP_INSERT) begin
            if (hit >= 0) begin
                r.status = ST_DUPLICATE;
            end else if (free_slot < 0) begin
                r.status = ST_FULL;
            end else begin
                slot_valid[free_slot] = 1'b1;
                slot_key[free_slot]   = key;
                slot_pay[free_slot]   = pay;
                occupancy++;
                if (occupied && collisions < 65535) begin
                    collisions++;
                end
            end
        end else if (hit < 0) begin
            r.status = ST_NOT_FOUND;
        end else if (op == OP_LOOKUP) begin
            r.found = slot_pay[hit];
        end else if (op == OP_UPDATE) begin
            slot_pay[hit] = pay;
        end else begin
            slot_valid[hit] = 1'b0;
            if (occupancy > 0) begin
                occupancy--;
            end
        end
        r.count = (occupancy > 511) ? CNT_W'(511) : CNT_W'(occupancy);
        r.coll  = COLL_W'(collisions);
        return r;
    endfunction

    task automatic check_field(string what, int want_v, int got_v);
        if (want_v != got_v) begin
            $display("%0t: %s expected %0d got %0d", $time, what, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            slot_valid = '{default: 1'b0};
            occupancy  = 0;
            collisions = 0;
            queued_replies.delete();
            o_pending <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (queued_replies.size() == 0) begin
                    $display("%0t: result word with none expected, status %0d count %0d",
                             $time, i_status, i_entry_count);
                    mismatches++;
                end else begin
                    oldest = queued_replies.pop_front();
                    check_field("status", oldest.status, i_status);
                    check_field("found_semester", oldest.found.semester, i_found_semester);
                    check_field("found_grade", oldest.found.grade, i_found_grade);
                    check_field("found_skill", oldest.found.skill, i_found_skill);
                    check_field("entry_count", oldest.count, i_entry_count);
                    check_field("collision_count", oldest.coll, i_collision_count);
                end
            end
            if (i_in_valid && i_in_ready) begin
                queued_replies.push_back(apply_table_op(t_opcode'(i_opcode), i_record_key,
                    t_payload'{skill: i_skill_score, grade: i_grade_hundredths,
                               semester: i_semester}));
            end
            o_pending <= queued_replies.size();
        end
    end

endmodule

>>> tb/keyed_record_hash_table_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_record_hash_table_test
// Drives directed and random table operations into the record table with
// bursty input and a stalling output side, and reports the verdict.
// ----------------------------------------------------------------------------
module keyed_record_hash_table_test;
    import krht_pkg::*;

    localparam int DIRECTED_WORDS = 22;
    localparam int RANDOM_WORDS   = 830;
    localparam int POOL_SIZE      = 48;
    localparam int HOT_BUCKETS    = 8;
    localparam int LONG_HOLD      = 400;
    localparam int STALL_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 30;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    logic [OP_W-1:0]     i_opcode = '0;
    logic [KEY_W-1:0]    i_record_key = '0;
    logic [SEM_W-1:0]    i_semester = '0;
    logic [GRADE_W-1:0]  i_grade_hundredths = '0;
    logic [SKILL_W-1:0]  i_skill_score = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic [SEM_W-1:0]    o_found_semester;
    logic [GRADE_W-1:0]  o_found_grade;
    logic [SKILL_W-1:0]  o_found_skill;
    logic [CNT_W-1:0]    o_entry_count;
    logic [COLL_W-1:0]   o_collision_count;

    int               fail_count;
    int               pending;
    int               burst_left = 0;
    bit               hold_due = 1'b0;
    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    keyed_record_hash_table u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_opcode           (i_opcode),
        .i_record_key       (i_record_key),
        .i_semester         (i_semester),
        .i_grade_hundredths (i_grade_hundredths),
        .i_skill_score      (i_skill_score),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_status           (o_status),
        .o_found_semester   (o_found_semester),
        .o_found_grade      (o_found_grade),
        .o_found_skill      (o_found_skill),
        .o_entry_count      (o_entry_count),
        .o_collision_count  (o_collision_count)
    );

    keyed_record_hash_table_checker u_check (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_valid),
        .i_in_ready         (o_ready),
        .i_opcode           (i_opcode),
        .i_record_key       (i_record_key),
        .i_semester         (i_semester),
        .i_grade_hundredths (i_grade_hundredths),
        .i_skill_score      (i_skill_score),
        .i_out_valid        (o_valid),
        .i_out_ready        (i_ready),
        .i_status           (o_status),
        .i_found_semester   (o_found_semester),
        .i_found_grade      (o_found_grade),
        .i_found_skill      (o_found_skill),
        .i_entry_count      (o_entry_count),
        .i_collision_count  (o_collision_count),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic offer_word(t_opcode op, logic [KEY_W-1:0] key, logic [SEM_W-1:0] sem,
                              logic [GRADE_W-1:0] grade, logic [SKILL_W-1:0] skill);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 16);
        end
        burst_left--;
        i_valid            <= 1'b1;
        i_opcode           <= op;
        i_record_key       <= key;
        i_semester         <= sem;
        i_grade_hundredths <= grade;
        i_skill_score      <= skill;
        do @(posedge i_clk); while (!o_ready);
    endtask

    initial begin : stimulus
        int               n;
        int               pick;
        t_opcode          op;
        logic [KEY_W-1:0] key;
        logic [5:0]       hot [HOT_BUCKETS];
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        offer_word(OP_INSERT, 31'd0, 4'd15, 10'd1000, 10'd1023);
        offer_word(OP_INSERT, 31'h7FFF_FFFF, 4'd0, 10'd0, 10'd0);
        offer_word(OP_LOOKUP, 31'd0, 4'd0, 10'd0, 10'd0);
        offer_word(OP_LOOKUP, 31'h7FFF_FFFF, 4'd15, 10'd1023, 10'd1023);
        offer_word(OP_INSERT, 31'd0, 4'd1, 10'd2, 10'd3);
        offer_word(OP_INSERT, 31'd64, 4'd3, 10'd300, 10'd700);
        offer_word(OP_INSERT, 31'd128, 4'd9, 10'd999, 10'd1);
        offer_word(OP_INSERT, 31'd192, 4'd12, 10'd50, 10'd60);
        offer_word(OP_INSERT, 31'd256, 4'd2, 10'd20, 10'd30);
        offer_word(OP_UPDATE, 31'd128, 4'd5, 10'd1023, 10'd512);
        offer_word(OP_LOOKUP, 31'd128, 4'd0, 10'd0, 10'd0);
        offer_word(OP_REMOVE, 31'd64, 4'd0, 10'd0, 10'd0);
        offer_word(OP_LOOKUP, 31'd64, 4'd0, 10'd0, 10'd0);
        offer_word(OP_UPDATE, 31'd64, 4'd7, 10'd77, 10'd777);
        offer_word(OP_REMOVE, 31'd64, 4'd0, 10'd0, 10'd0);
        offer_word(OP_INSERT, 31'd256, 4'd2, 10'd20, 10'd30);
        offer_word(OP_LOOKUP, 31'd256, 4'd0, 10'd0, 10'd0);
        offer_word(OP_REMOVE, 31'h7FFF_FFFF, 4'd0, 10'd0, 10'd0);
        offer_word(OP_LOOKUP, 31'h7FFF_FFFF, 4'd0, 10'd0, 10'd0);
        offer_word(OP_INSERT, 31'h4000_0000, 4'd8, 10'd500, 10'd256);
        offer_word(OP_UPDATE, 31'd0, 4'd10, 10'd1001, 10'd1023);
        offer_word(OP_LOOKUP, 31'd0, 4'd0, 10'd0, 10'd0);

        // Most keys fall into a few buckets so that chains fill, overflow and drain.
        for (n = 0; n < HOT_BUCKETS; n++) begin
            hot[n] = 6'($urandom_range(0, 63));
        end
        for (n = 0; n < POOL_SIZE; n++) begin
            key_pool[n] = {(KEY_W-6)'($urandom), hot[n % HOT_BUCKETS]};
        end

        for (n = 0; n < RANDOM_WORDS; n++) begin
            if (n == 200) begin
                hold_due = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                op = OP_INSERT;
            end else if (pick < 60) begin
                op = OP_LOOKUP;
            end else if (pick < 80) begin
                op = OP_UPDATE;
            end else begin
                op = OP_REMOVE;
            end
            if ($urandom_range(0, 9) == 0) begin
                key = KEY_W'($urandom);
            end else begin
                key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            end
            offer_word(op, key, SEM_W'($urandom_range(0, 15)),
                       GRADE_W'($urandom_range(0, 1023)), SKILL_W'($urandom_range(0, 1023)));
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin : receiver
        int mode;
        int span;
        int k;
        bit hold_done;
        hold_done = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_due && !hold_done) begin
                hold_done = 1'b1;
                i_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                mode = $urandom_range(0, 2);
                span = $urandom_range(10, 80);
                for (k = 0; k < span; k++) begin
                    case (mode)
                        0: begin
                            i_ready <= 1'b1;
                        end
                        1: begin
                            i_ready <= ($urandom_range(0, 1) == 1);
                        end
                        default: begin
                            i_ready <= ((k % 5) < 2);
                        end
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("end of test: mismatches");
        $finish;
    end

endmodule
